[rtl/interrupt_controller_72_line_macros.svh]
// assertion macros for the 72-line interrupt controller
`ifndef INTERRUPT_CONTROLLER_72_LINE_MACROS_SVH
`define INTERRUPT_CONTROLLER_72_LINE_MACROS_SVH

`ifndef ASSERT_OFF
// checked after reset is released, uses clk and rst_n of the enclosing module
`define ICL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("icl assertion failed");
// checked on every edge, reset included
`define ICL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("icl assertion failed");
`else
`define ICL_ASSERT(lbl, prop)
`define ICL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/icl_pkg.sv]
// shared types, constants and helper functions for the interrupt controller
`default_nettype none

package icl_pkg;

  // line counts and masks
  localparam int unsigned ARM_LINES  = 8;
  localparam int unsigned GPU_LINES  = 64;
  localparam int unsigned BASIC_EN_W = 10;
  localparam int unsigned SC_LINES   = 11;

  // gpu lines mirrored in basic pending bits 10-20
  localparam logic [5:0] SHORTCUT_LINE [SC_LINES] =
    '{6'd7, 6'd9, 6'd10, 6'd18, 6'd19, 6'd53, 6'd54, 6'd55, 6'd56, 6'd57, 6'd62};

  // item kinds on tuser
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // register word indexes
  localparam logic [3:0] REG_BASIC_PEND = 4'd0;
  localparam logic [3:0] REG_PEND1      = 4'd1;
  localparam logic [3:0] REG_PEND2      = 4'd2;
  localparam logic [3:0] REG_FIQ        = 4'd3;
  localparam logic [3:0] REG_ENA1       = 4'd4;
  localparam logic [3:0] REG_ENA2       = 4'd5;
  localparam logic [3:0] REG_BASIC_ENA  = 4'd6;
  localparam logic [3:0] REG_DIS1       = 4'd7;
  localparam logic [3:0] REG_DIS2       = 4'd8;
  localparam logic [3:0] REG_BASIC_DIS  = 4'd9;

  // queue sizing
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // decoded operation
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } icl_op_t;

  // classified item passed from front to back
  typedef struct packed {
    icl_op_t     op;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  arm_lines;
    logic [31:0] gpu_lines_low;
    logic [31:0] gpu_lines_high;
  } icl_item_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } icl_qstat_t;

  // result fields
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic        vector_valid;
    logic [6:0]  vector;
  } icl_result_t;

  // index of lowest set bit in a byte, zero when empty
  function automatic logic [2:0] lsb8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // index of lowest set bit in a word: first busy byte, then bit within it
  function automatic logic [4:0] lsb32(input logic [31:0] v);
    logic [3:0] grp;
    logic [2:0] g3;
    logic [1:0] gi;
    logic [7:0] byte_v;
    for (int j = 0; j < 4; j++) begin
      grp[j] = |v[8*j +: 8];
    end
    g3     = lsb8({4'b0, grp});
    gi     = g3[1:0];
    byte_v = v[{gi, 3'b000} +: 8];
    return {gi, lsb8(byte_v)};
  endfunction

endpackage

`default_nettype wire

[rtl/icl_front.sv]
// front end: accepts items and classifies them into queue entries
`default_nettype none

module icl_front
  import icl_pkg::*;
(
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_arm_lines,
  input  wire logic [31:0] in_gpu_lines_low,
  input  wire logic [31:0] in_gpu_lines_high,
  input  wire logic [3:0]  in_reg_index,
  input  wire logic [31:0] in_write_data,
  input  wire icl_qstat_t  qstat_i,
  output logic             push_o,
  output icl_item_t        item_o
);

  icl_op_t op;

  // take an item whenever the queue has room
  assign in_tready = !qstat_i.full;
  assign push_o    = in_tvalid && !qstat_i.full;

  // classify by mode, writes only to enable and disable words count
  always_comb begin
    case (in_mode)
      MODE_SAMPLE: op = OP_SAMPLE;
      MODE_WRITE: begin
        if (in_reg_index inside {[REG_ENA1 : REG_BASIC_DIS]}) op = OP_WRITE;
        else op = OP_NONE;
      end
      MODE_READ:   op = OP_READ;
      default:     op = OP_NONE;
    endcase
  end

  assign item_o.op             = op;
  assign item_o.reg_index      = in_reg_index;
  assign item_o.write_data     = in_write_data;
  assign item_o.arm_lines      = in_arm_lines;
  assign item_o.gpu_lines_low  = in_gpu_lines_low;
  assign item_o.gpu_lines_high = in_gpu_lines_high;

endmodule

`default_nettype wire

[rtl/icl_queue.sv]
// short queue between front and back
`default_nettype none
`include "interrupt_controller_72_line_macros.svh"

module icl_queue
  import icl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_i,
  input  wire icl_item_t push_item_i,
  input  wire logic      pop_i,
  output icl_qstat_t     qstat_o,
  output icl_item_t      head_o
);

  icl_item_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   q_cnt_r, q_cnt_nxt;

  assign qstat_o.full  = (q_cnt_r == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (q_cnt_r == '0);
  assign head_o        = q_mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push_i) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop_i)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push_i && !pop_i) q_cnt_nxt = q_cnt_r + 1'b1;
    else if (!push_i && pop_i) q_cnt_nxt = q_cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_i) q_mem_r[wr_ptr_r] <= push_item_i;
  end

  `ICL_ASSERT(a_q_cnt_max, q_cnt_r <= QCNT_W'(QDEPTH))
  `ICL_ASSERT(a_q_no_overflow, (push_i && qstat_o.full) |-> pop_i)
  `ICL_ASSERT(a_q_no_underflow, pop_i |-> !qstat_o.empty)
  `ICL_ASSERT(a_q_empty_ptrs, qstat_o.empty |-> (wr_ptr_r == rd_ptr_r))

endmodule

`default_nettype wire

[rtl/icl_back.sv]
// back end: applies items to the mask and level state, builds the result
`default_nettype none
`include "interrupt_controller_72_line_macros.svh"

module icl_back
  import icl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire icl_qstat_t qstat_i,
  input  wire icl_item_t  head_i,
  output logic            pop_o,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output icl_result_t     res_o
);

  logic [ARM_LINES-1:0]  arm_raw_r, arm_raw_nxt;
  logic [GPU_LINES-1:0]  gpu_raw_r, gpu_raw_nxt;
  logic [BASIC_EN_W-1:0] basic_en_r, basic_en_nxt;
  logic [GPU_LINES-1:0]  gpu_en_r, gpu_en_nxt;
  logic                  out_vld_r;
  icl_result_t           res_r, res_nxt;

  logic [GPU_LINES-1:0]  gp;
  logic [ARM_LINES-1:0]  arm_pend;
  logic [SC_LINES-1:0]   sc_pend;
  logic                  p1_bit, p2_bit;
  logic [31:0]           basic;
  logic [6:0]            sc_vec;
  logic [6:0]            vec;

  // pop when the output register is free or being drained
  assign pop_o = !qstat_i.empty && (!out_vld_r || out_tready);

  // state update for the head item
  always_comb begin
    arm_raw_nxt  = arm_raw_r;
    gpu_raw_nxt  = gpu_raw_r;
    basic_en_nxt = basic_en_r;
    gpu_en_nxt   = gpu_en_r;
    if (head_i.op == OP_SAMPLE) begin
      arm_raw_nxt = head_i.arm_lines;
      gpu_raw_nxt = {head_i.gpu_lines_high, head_i.gpu_lines_low};
    end else if (head_i.op == OP_WRITE) begin
      case (head_i.reg_index)
        REG_ENA1:      gpu_en_nxt = gpu_en_r | {32'h0, head_i.write_data};
        REG_ENA2:      gpu_en_nxt = gpu_en_r | {head_i.write_data, 32'h0};
        REG_BASIC_ENA: basic_en_nxt = basic_en_r | head_i.write_data[BASIC_EN_W-1:0];
        REG_DIS1:      gpu_en_nxt = gpu_en_r & ~{32'h0, head_i.write_data};
        REG_DIS2:      gpu_en_nxt = gpu_en_r & ~{head_i.write_data, 32'h0};
        REG_BASIC_DIS: basic_en_nxt = basic_en_r & ~head_i.write_data[BASIC_EN_W-1:0];
        default:       gpu_en_nxt = gpu_en_r;
      endcase
    end
  end

  // pending words from the updated state
  always_comb begin
    gp       = gpu_raw_nxt & gpu_en_nxt;
    arm_pend = arm_raw_nxt & basic_en_nxt[ARM_LINES-1:0];
    p1_bit   = (|gp[31:0]) && basic_en_nxt[ARM_LINES];
    p2_bit   = (|gp[63:32]) && basic_en_nxt[ARM_LINES+1];
    for (int k = 0; k < SC_LINES; k++) begin
      sc_pend[k] = gp[SHORTCUT_LINE[k]];
    end
    basic = {11'h0, sc_pend, p2_bit, p1_bit, arm_pend};
  end

  // lowest shortcut line
  always_comb begin
    sc_vec = '0;
    for (int k = SC_LINES - 1; k >= 0; k--) begin
      if (sc_pend[k]) sc_vec = 7'(ARM_LINES) + {1'b0, SHORTCUT_LINE[k]};
    end
  end

  // vector in driver order: arm, shortcuts, pend1, pend2
  always_comb begin
    if (|arm_pend)   vec = {4'b0, lsb8(arm_pend)};
    else if (|sc_pend) vec = sc_vec;
    else if (p1_bit) vec = 7'(ARM_LINES) + {2'b0, lsb32(gp[31:0])};
    else if (p2_bit) vec = 7'(ARM_LINES + 32) + {2'b0, lsb32(gp[63:32])};
    else             vec = '0;
  end

  // read mux and result assembly
  always_comb begin
    res_nxt.read_data = '0;
    if (head_i.op == OP_READ) begin
      case (head_i.reg_index)
        REG_BASIC_PEND:         res_nxt.read_data = basic;
        REG_PEND1:              res_nxt.read_data = gp[31:0];
        REG_PEND2:              res_nxt.read_data = gp[63:32];
        REG_ENA1, REG_DIS1:     res_nxt.read_data = gpu_en_nxt[31:0];
        REG_ENA2, REG_DIS2:     res_nxt.read_data = gpu_en_nxt[63:32];
        REG_BASIC_ENA, REG_BASIC_DIS:
          res_nxt.read_data = {22'h0, basic_en_nxt};
        default:                res_nxt.read_data = '0;
      endcase
    end
    res_nxt.irq_request  = |basic;
    res_nxt.vector_valid = |basic;
    res_nxt.vector       = vec;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_raw_r  <= '0;
      gpu_raw_r  <= '0;
      basic_en_r <= '0;
      gpu_en_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (pop_o) begin
        arm_raw_r  <= arm_raw_nxt;
        gpu_raw_r  <= gpu_raw_nxt;
        basic_en_r <= basic_en_nxt;
        gpu_en_r   <= gpu_en_nxt;
        out_vld_r  <= 1'b1;
      end else if (out_tready) begin
        out_vld_r  <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop_o) res_r <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign res_o      = res_r;

  `ICL_ASSERT(a_pop_fills_out, pop_o |=> out_vld_r)
  `ICL_ASSERT(a_valid_eq_irq, out_vld_r |-> (res_r.vector_valid == res_r.irq_request))
  `ICL_ASSERT(a_vec_range, (out_vld_r && res_r.vector_valid) |-> (res_r.vector <= 7'd71))
  `ICL_ASSERT(a_vec_zero, (out_vld_r && !res_r.vector_valid) |-> (res_r.vector == 7'd0))
  `ICL_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_vld_r)

endmodule

`default_nettype wire

[rtl/interrupt_controller_72_line.sv]
// top level of the 72-line level-sensitive interrupt controller
// path: an accepted item is written into the queue, then popped into the result
//   register when that is free or being drained, which raises out_tvalid
// throughput: one item per cycle unless out_tready stalls; back-end masks, levels
//   and priority vector are updated combinationally behind a two-entry queue
// reset: synchronous active-low rst_n clears all levels and enables (every line
//   disabled), empties the queue and drops out_tvalid
`default_nettype none

module interrupt_controller_72_line
  import icl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // arm_lines[7:0], gpu_lines_low[39:8], gpu_lines_high[71:40],
  // reg_index[75:72], write_data[107:76], zero fill[111:108]
  input  wire logic [111:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // read_data[31:0], irq_request[32], vector_valid[33], vector[40:34],
  // zero fill[47:41]
  output logic [47:0]       out_tdata
);

  icl_qstat_t  qstat;
  icl_item_t   push_item;
  icl_item_t   head_item;
  icl_result_t res;
  logic        push;
  logic        pop;

  // classify incoming items
  icl_front u_front (
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_mode           (in_tuser),
    .in_arm_lines      (in_tdata[7:0]),
    .in_gpu_lines_low  (in_tdata[39:8]),
    .in_gpu_lines_high (in_tdata[71:40]),
    .in_reg_index      (in_tdata[75:72]),
    .in_write_data     (in_tdata[107:76]),
    .qstat_i           (qstat),
    .push_o            (push),
    .item_o            (push_item)
  );

  // decoupling queue
  icl_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .qstat_o     (qstat),
    .head_o      (head_item)
  );

  // state update and result register
  icl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat_i    (qstat),
    .head_i     (head_item),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_o      (res)
  );

  // pack result item
  assign out_tdata = {7'h0, res.vector, res.vector_valid, res.irq_request, res.read_data};

endmodule

`default_nettype wire
